// ----- rtl/knn_pkg.sv -----
// Shared types, constants and state codes for the nearest-neighbour classifier.
package knn_pkg;

    // Default sizes handed to the top level as parameter defaults.
    localparam int STORE_DEPTH_DEF = 256;
    localparam int NEIGHBOURS_DEF  = 15;

    // Fixed field widths.
    localparam int FEAT_W   = 16;
    localparam int NUM_FEAT = 4;
    localparam int LABEL_W  = 8;
    localparam int SQ_W     = 2 * FEAT_W;
    localparam int DIST_W   = 34;
    localparam int EX_W     = LABEL_W + NUM_FEAT * FEAT_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Request codes.
    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t STATUS_STORED     = 2'd0;
    localparam status_t STATUS_FULL       = 2'd1;
    localparam status_t STATUS_CLASSIFIED = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_READ,
        S_DIST,
        S_CMP,
        S_SCAN,
        S_VOTE,
        S_DONE
    } knn_state_t;

endpackage

// ----- rtl/knn_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/knn_classifier.sv -----
// k-nearest-neighbour classifier: example store, distance sequencer and vote.
//
// Each item either adds a labelled example of four 16-bit features or classifies a query.
// An add goes to the done state after acceptance, and its result is loaded into the output
// register once that register is free; the input is ready again as the result is loaded.
// A classify over N stored examples with K neighbour slots clears the slots, then for each
// example does one store read, a pass of the four features through the single
// difference-and-square unit feeding the distance accumulator and one compare; each of the R
// examples (at most N) that displace a slot is followed by a scan of the K slots for the new
// worst one, and the vote then walks the K slots once. The input is not ready while a classify
// runs; a new item is taken while the previous result still waits at the output register.
module knn_classifier #(
    parameter int STORE_DEPTH = knn_pkg::STORE_DEPTH_DEF,
    parameter int NEIGHBOURS  = knn_pkg::NEIGHBOURS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [knn_pkg::LABEL_W-1:0] label,
    input  logic [knn_pkg::FEAT_W-1:0]  feature_0,
    input  logic [knn_pkg::FEAT_W-1:0]  feature_1,
    input  logic [knn_pkg::FEAT_W-1:0]  feature_2,
    input  logic [knn_pkg::FEAT_W-1:0]  feature_3,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [knn_pkg::LABEL_W-1:0] class_label,
    output knn_pkg::status_t            status
);

    import knn_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int VW = $clog2(NEIGHBOURS + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(STORE_DEPTH);
    localparam logic [SW-1:0] SLOT_LAST = SW'(NEIGHBOURS - 1);

    knn_state_t state_reg, state_next;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      ex_idx_reg;
    logic [2:0]         feat_cnt_reg;
    logic [FEAT_W-1:0]  query_reg [NUM_FEAT];
    logic [SQ_W-1:0]    sq_reg;
    logic [DIST_W-1:0]  acc_reg;
    logic [DIST_W-1:0]  slot_dist_reg  [NEIGHBOURS];
    logic [LABEL_W-1:0] slot_label_reg [NEIGHBOURS];
    logic [SW-1:0]      worst_idx_reg;
    logic [DIST_W-1:0]  worst_dist_reg;
    logic [SW-1:0]      slot_idx_reg;
    logic [VW-1:0]      best_cnt_reg;
    logic [LABEL_W-1:0] best_label_reg;
    logic [LABEL_W-1:0] res_label_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    logic [LABEL_W-1:0] class_label_reg;
    status_t            status_reg;

    logic               ram_we;
    logic               ram_re;
    logic [EX_W-1:0]    ram_rdata;

    logic               in_fire;
    logic               out_free;
    logic               is_full;
    logic               ex_last;
    logic               slot_last;
    logic               closer;

    logic [FEAT_W-1:0]  feat_a;
    logic [FEAT_W-1:0]  feat_b;
    logic [FEAT_W-1:0]  diff;
    logic [SQ_W-1:0]    sq;

    logic [LABEL_W-1:0]    vote_label;
    logic [NEIGHBOURS-1:0] vote_eq;
    logic [VW-1:0]         vote_cnt;

    // Example store: label over the four packed features.
    knn_ram #(
        .WIDTH (EX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({label, feature_3, feature_2, feature_1, feature_0}),
        .re    (ram_re),
        .raddr (ex_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Handshake and loop conditions.
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_full   = (count_reg == DEPTH_C);
    assign ex_last   = ((ex_idx_reg + CW'(1)) == count_reg);
    assign slot_last = (slot_idx_reg == SLOT_LAST);
    assign closer    = (acc_reg < worst_dist_reg);

    // Shared difference-and-square unit, one feature a cycle.
    always_comb
    begin
        feat_a = ram_rdata[feat_cnt_reg[1:0] * FEAT_W +: FEAT_W];
        feat_b = query_reg[feat_cnt_reg[1:0]];
        diff   = (feat_a >= feat_b) ? (feat_a - feat_b) : (feat_b - feat_a);
        sq     = diff * diff;
    end

    // Vote: count how many slots share the label of the current slot.
    always_comb
    begin
        vote_label = slot_label_reg[slot_idx_reg];
        for (int j = 0; j < NEIGHBOURS; j++)
        begin
            vote_eq[j] = (slot_label_reg[j] == vote_label);
        end
        vote_cnt = VW'($countones(vote_eq));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (func == FUNC_CLASSIFY) ? S_INIT : S_DONE;
                end
            end
            S_INIT:
            begin
                state_next = (count_reg == '0) ? S_VOTE : S_READ;
            end
            S_READ:
            begin
                state_next = S_DIST;
            end
            S_DIST:
            begin
                if (feat_cnt_reg == 3'd4)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                priority if (closer)
                begin
                    state_next = S_SCAN;
                end
                else if (ex_last)
                begin
                    state_next = S_VOTE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SCAN:
            begin
                if (slot_last)
                begin
                    state_next = ex_last ? S_VOTE : S_READ;
                end
            end
            S_VOTE:
            begin
                if (slot_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        ram_re   = (state_reg == S_READ);
        ram_we   = in_fire && (func == FUNC_ADD) && !is_full;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Example count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ram_we)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // Datapath: query capture, slot clearing, distance accumulation, slot update, scan and vote.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    query_reg[0] <= feature_0;
                    query_reg[1] <= feature_1;
                    query_reg[2] <= feature_2;
                    query_reg[3] <= feature_3;
                    res_label_reg  <= '0;
                    res_status_reg <= is_full ? STATUS_FULL : STATUS_STORED;
                end
            end
            S_INIT:
            begin
                for (int i = 0; i < NEIGHBOURS; i++)
                begin
                    slot_dist_reg[i]  <= DIST_MAX;
                    slot_label_reg[i] <= '0;
                end
                worst_idx_reg  <= '0;
                worst_dist_reg <= DIST_MAX;
                ex_idx_reg     <= '0;
                slot_idx_reg   <= '0;
                best_cnt_reg   <= '0;
                best_label_reg <= '0;
            end
            S_READ:
            begin
                acc_reg      <= '0;
                feat_cnt_reg <= '0;
            end
            S_DIST:
            begin
                if (feat_cnt_reg != 3'd4)
                begin
                    sq_reg <= sq;
                end
                if (feat_cnt_reg != 3'd0)
                begin
                    acc_reg <= acc_reg + DIST_W'(sq_reg);
                end
                feat_cnt_reg <= feat_cnt_reg + 3'd1;
            end
            S_CMP:
            begin
                if (closer)
                begin
                    slot_dist_reg[worst_idx_reg]  <= acc_reg;
                    slot_label_reg[worst_idx_reg] <= ram_rdata[EX_W-1 -: LABEL_W];
                    slot_idx_reg <= '0;
                end
                else if (!ex_last)
                begin
                    ex_idx_reg <= ex_idx_reg + CW'(1);
                end
            end
            S_SCAN:
            begin
                // The first slot holding the largest distance becomes the worst one.
                if (slot_idx_reg == '0)
                begin
                    worst_idx_reg  <= '0;
                    worst_dist_reg <= slot_dist_reg[0];
                end
                else if (slot_dist_reg[slot_idx_reg] > worst_dist_reg)
                begin
                    worst_idx_reg  <= slot_idx_reg;
                    worst_dist_reg <= slot_dist_reg[slot_idx_reg];
                end
                if (slot_last)
                begin
                    slot_idx_reg <= '0;
                    if (!ex_last)
                    begin
                        ex_idx_reg <= ex_idx_reg + CW'(1);
                    end
                end
                else
                begin
                    slot_idx_reg <= slot_idx_reg + SW'(1);
                end
            end
            S_VOTE:
            begin
                if (vote_cnt > best_cnt_reg)
                begin
                    best_cnt_reg   <= vote_cnt;
                    best_label_reg <= vote_label;
                end
                if (slot_last)
                begin
                    res_label_reg  <= (vote_cnt > best_cnt_reg) ? vote_label : best_label_reg;
                    res_status_reg <= STATUS_CLASSIFIED;
                end
                else
                begin
                    slot_idx_reg <= slot_idx_reg + SW'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: loaded from the finished result once the previous item has gone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            class_label_reg <= res_label_reg;
            status_reg      <= res_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign class_label = class_label_reg;
    assign status      = status_reg;

    // The store never holds more examples than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("example count beyond store depth");

    // A stored example advances the count by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("example count did not advance on store");

    // While walking the store, the example index stays below the count.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_DIST || state_reg == S_CMP ||
         state_reg == S_SCAN) |-> (ex_idx_reg < count_reg))
        else $error("example index outside filled store");

    // A finished result reaches the output register in the next cycle.
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> out_valid_reg)
        else $error("finished result not presented");

    // A presented result always carries one of the defined status codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == STATUS_STORED || status_reg == STATUS_FULL ||
                           status_reg == STATUS_CLASSIFIED))
        else $error("invalid status presented");

endmodule
